>>> rtl/oba_pkg.sv
// ----------------------------------------------------------------------------
// oba_pkg
// Shared widths, constants and types for the oriented box bound pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package oba_pkg;

   localparam int COORD_W = 32;
   localparam int EDGE_W  = 31;
   localparam int QUAT_W  = 16;
   localparam int PROD_W  = 2 * QUAT_W;
   localparam int MAT_W   = PROD_W + 2;
   localparam int MAG_W   = 32;
   localparam int FRAC_W  = 28;
   localparam int FULL_W  = MAG_W + EDGE_W;
   localparam int SUM_W   = FULL_W + 2;
   localparam int SIZE_W  = 32;
   localparam int QUOT_W  = SUM_W - FRAC_W;
   localparam int LATENCY = 5;

   localparam logic signed [MAT_W-1:0] MAT_ONE    = MAT_W'(64'sd1 <<< FRAC_W);
   localparam logic [FULL_W:0]         ROUND_HALF = (FULL_W + 1)'(64'd1 << (FRAC_W - 1));
   localparam logic [SIZE_W-1:0]       SIZE_SAT   = {SIZE_W{1'b1}};

   typedef struct packed {
      logic signed [PROD_W-1:0] xx;
      logic signed [PROD_W-1:0] yy;
      logic signed [PROD_W-1:0] zz;
      logic signed [PROD_W-1:0] xy;
      logic signed [PROD_W-1:0] xz;
      logic signed [PROD_W-1:0] yz;
      logic signed [PROD_W-1:0] wx;
      logic signed [PROD_W-1:0] wy;
      logic signed [PROD_W-1:0] wz;
   } quat_prod_type;

   typedef logic [2:0][EDGE_W-1:0]  edge_vec_type;
   typedef logic [2:0][MAG_W-1:0]   mag_row_type;
   typedef mag_row_type [2:0]       mag_mat_type;
   typedef logic [2:0][SIZE_W-1:0]  size_vec_type;
   typedef logic [2:0][COORD_W-1:0] coord_vec_type;

endpackage

`default_nettype wire

>>> rtl/oba_rotate.sv
// ----------------------------------------------------------------------------
// oba_rotate
// Two-stage quaternion to rotation matrix: products, then absolute entries.
// ----------------------------------------------------------------------------
`default_nettype none

module oba_rotate
   import oba_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic signed [QUAT_W-1:0] in_w,
   input  wire logic signed [QUAT_W-1:0] in_x,
   input  wire logic signed [QUAT_W-1:0] in_y,
   input  wire logic signed [QUAT_W-1:0] in_z,
   input  wire edge_vec_type             in_edge,
   output logic                          out_valid,
   output mag_mat_type                   out_mag,
   output edge_vec_type                  out_edge
);

   logic          valid1_ff;
   quat_prod_type prod_in;
   quat_prod_type prod_ff;
   edge_vec_type  edge1_ff;

   logic          valid2_ff;
   mag_mat_type   mag_in;
   mag_mat_type   mag_ff;
   edge_vec_type  edge2_ff;

   function automatic logic [MAG_W-1:0] abs_entry(input logic signed [MAT_W-1:0] v);
      logic signed [MAT_W-1:0] a;
      a = (v < 0) ? -v : v;
      return a[MAG_W-1:0];
   endfunction

   always_comb begin
      prod_in.xx = in_x * in_x;
      prod_in.yy = in_y * in_y;
      prod_in.zz = in_z * in_z;
      prod_in.xy = in_x * in_y;
      prod_in.xz = in_x * in_z;
      prod_in.yz = in_y * in_z;
      prod_in.wx = in_w * in_x;
      prod_in.wy = in_w * in_y;
      prod_in.wz = in_w * in_z;
   end

   always_comb begin
      logic signed [MAT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
      r00 = MAT_ONE - ((MAT_W'(prod_ff.yy) + MAT_W'(prod_ff.zz)) <<< 1);
      r01 = (MAT_W'(prod_ff.xy) - MAT_W'(prod_ff.wz)) <<< 1;
      r02 = (MAT_W'(prod_ff.xz) + MAT_W'(prod_ff.wy)) <<< 1;
      r10 = (MAT_W'(prod_ff.xy) + MAT_W'(prod_ff.wz)) <<< 1;
      r11 = MAT_ONE - ((MAT_W'(prod_ff.xx) + MAT_W'(prod_ff.zz)) <<< 1);
      r12 = (MAT_W'(prod_ff.yz) - MAT_W'(prod_ff.wx)) <<< 1;
      r20 = (MAT_W'(prod_ff.xz) - MAT_W'(prod_ff.wy)) <<< 1;
      r21 = (MAT_W'(prod_ff.yz) + MAT_W'(prod_ff.wx)) <<< 1;
      r22 = MAT_ONE - ((MAT_W'(prod_ff.xx) + MAT_W'(prod_ff.yy)) <<< 1);
      mag_in[0][0] = abs_entry(r00);
      mag_in[0][1] = abs_entry(r01);
      mag_in[0][2] = abs_entry(r02);
      mag_in[1][0] = abs_entry(r10);
      mag_in[1][1] = abs_entry(r11);
      mag_in[1][2] = abs_entry(r12);
      mag_in[2][0] = abs_entry(r20);
      mag_in[2][1] = abs_entry(r21);
      mag_in[2][2] = abs_entry(r22);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
      prod_ff  <= prod_in;
      edge1_ff <= in_edge;
      mag_ff   <= mag_in;
      edge2_ff <= edge1_ff;
   end

   assign out_valid = valid2_ff;
   assign out_mag   = mag_ff;
   assign out_edge  = edge2_ff;

endmodule

`default_nettype wire

>>> rtl/oba_extent.sv
// ----------------------------------------------------------------------------
// oba_extent
// Three-stage extent: |R| times edge, partial sums, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module oba_extent
   import oba_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire mag_mat_type  in_mag,
   input  wire edge_vec_type in_edge,
   output logic              out_valid,
   output size_vec_type      out_size
);

   logic               valid_a_ff;
   logic [FULL_W-1:0]  term_in [3][3];
   logic [FULL_W-1:0]  term_ff [3][3];

   logic               valid_b_ff;
   logic [FULL_W:0]    pair_in [3];
   logic [FULL_W:0]    pair_ff [3];
   logic [FULL_W:0]    bias_in [3];
   logic [FULL_W:0]    bias_ff [3];

   logic               valid_c_ff;
   size_vec_type       size_in;
   size_vec_type       size_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            term_in[i][j] = FULL_W'(in_mag[i][j]) * FULL_W'(in_edge[j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pair_in[i] = (FULL_W + 1)'(term_ff[i][0]) + (FULL_W + 1)'(term_ff[i][1]);
         bias_in[i] = (FULL_W + 1)'(term_ff[i][2]) + ROUND_HALF;
      end
   end

   always_comb begin
      logic [SUM_W-1:0]  total;
      logic [QUOT_W-1:0] quot;
      size_in = '0;
      for (int i = 0; i < 3; i++) begin
         total = SUM_W'(pair_ff[i]) + SUM_W'(bias_ff[i]);
         quot  = total[SUM_W-1:FRAC_W];
         size_in[i] = (|quot[QUOT_W-1:SIZE_W]) ? SIZE_SAT : quot[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
      term_ff <= term_in;
      pair_ff <= pair_in;
      bias_ff <= bias_in;
      size_ff <= size_in;
   end

   assign out_valid = valid_c_ff;
   assign out_size  = size_ff;

endmodule

`default_nettype wire

>>> rtl/oriented_box_to_aabb_top.sv
// ----------------------------------------------------------------------------
// oriented_box_to_aabb_top
// Axis-aligned bound of an oriented box given center, edges and quaternion.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while busy is low; busy is registered,
// set during reset and cleared at the first clock edge without reset, low otherwise.
// Pipeline: 2 matrix stages, 3 extent stages (multiply, partial sum, round).
// Reset: synchronous, clears all valid bits; results are never held off.
`default_nettype none

module oriented_box_to_aabb_top
   import oba_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [COORD_W-1:0] req_center_x,
   input  wire logic signed [COORD_W-1:0] req_center_y,
   input  wire logic signed [COORD_W-1:0] req_center_z,
   input  wire logic [EDGE_W-1:0]         req_edge_x,
   input  wire logic [EDGE_W-1:0]         req_edge_y,
   input  wire logic [EDGE_W-1:0]         req_edge_z,
   input  wire logic signed [QUAT_W-1:0]  req_rot_w,
   input  wire logic signed [QUAT_W-1:0]  req_rot_x,
   input  wire logic signed [QUAT_W-1:0]  req_rot_y,
   input  wire logic signed [QUAT_W-1:0]  req_rot_z,
   output logic                           rsp_strobe,
   output logic signed [COORD_W-1:0]      rsp_bound_center_x,
   output logic signed [COORD_W-1:0]      rsp_bound_center_y,
   output logic signed [COORD_W-1:0]      rsp_bound_center_z,
   output logic [SIZE_W-1:0]              rsp_bound_size_x,
   output logic [SIZE_W-1:0]              rsp_bound_size_y,
   output logic [SIZE_W-1:0]              rsp_bound_size_z
);

   logic          busy_ff;
   logic          accept;
   edge_vec_type  req_edge;
   coord_vec_type center_in;
   coord_vec_type center_ff [LATENCY];

   logic          mat_valid;
   mag_mat_type   mat_mag;
   edge_vec_type  mat_edge;
   size_vec_type  bound_size;

   assign accept    = start & ~busy_ff;
   assign req_edge  = {req_edge_z, req_edge_y, req_edge_x};
   assign center_in = {req_center_z, req_center_y, req_center_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
      center_ff[0] <= center_in;
      for (int k = 1; k < LATENCY; k++) begin
         center_ff[k] <= center_ff[k-1];
      end
   end

   oba_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_w      (req_rot_w),
      .in_x      (req_rot_x),
      .in_y      (req_rot_y),
      .in_z      (req_rot_z),
      .in_edge   (req_edge),
      .out_valid (mat_valid),
      .out_mag   (mat_mag),
      .out_edge  (mat_edge)
   );

   oba_extent u_extent (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .in_mag    (mat_mag),
      .in_edge   (mat_edge),
      .out_valid (rsp_strobe),
      .out_size  (bound_size)
   );

   assign busy               = busy_ff;
   assign rsp_bound_center_x = center_ff[LATENCY-1][0];
   assign rsp_bound_center_y = center_ff[LATENCY-1][1];
   assign rsp_bound_center_z = center_ff[LATENCY-1][2];
   assign rsp_bound_size_x   = bound_size[0];
   assign rsp_bound_size_y   = bound_size[1];
   assign rsp_bound_size_z   = bound_size[2];

endmodule

`default_nettype wire
